/* hdl/svfc_pkg.sv */
// Shared types and constants for the serial value frame codec.
// No dependencies; imported by every module of the block.
package svfc_pkg;

    localparam int CMD_DEPTH_DEFAULT = 4;

    localparam logic [7:0]  HDR_WORD32    = 8'h11;
    localparam logic [7:0]  HDR_WORD16    = 8'h12;
    localparam logic [7:0]  END_BYTE      = 8'h10;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    typedef enum logic [1:0] {
        OP_RX_BYTE = 2'd0,
        OP_TICK    = 2'd1,
        OP_SEND    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CAUSE_HEADER  = 2'd0,
        CAUSE_TIMEOUT = 2'd1,
        CAUSE_END     = 2'd2
    } cause_t;

    typedef enum logic [1:0] {
        RX_IDLE   = 2'd0,
        RX_GATHER = 2'd1,
        RX_END    = 2'd2
    } rx_phase_t;

    typedef enum logic {
        REG_RX_FRAME_KIND = 1'b0,
        REG_TIMEOUT_TICKS = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  rx_data_byte;
        logic [31:0] send_word;
        logic        send_kind;
    } in_item_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_data_byte;
        logic        tx_last;
        logic        rx_done;
        logic [31:0] rx_word;
        logic        rx_fail;
        logic [1:0]  fail_cause;
    } out_item_t;

    // command from front to back: a send request or one receive report
    typedef struct packed {
        logic        is_send;
        logic [31:0] word;
        logic        send_kind;
        logic        rx_done;
        logic        rx_fail;
        logic [1:0]  fail_cause;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

/* hdl/svfc_front.sv */
// Front end: config registers, receive deframer state, command issue.
// Depends on svfc_pkg.
module svfc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  svfc_pkg::in_item_t  in_item,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    output logic                cmd_push,
    output svfc_pkg::cmd_t      cmd
);
    import svfc_pkg::*;

    logic        kind_reg;
    logic [15:0] timeout_reg;
    rx_phase_t   phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] acc_reg, acc_next;
    logic [15:0] elapsed_reg, elapsed_next;

    logic [2:0]  need;
    logic [7:0]  hdr;
    logic [2:0]  cnt_inc;
    logic [16:0] elapsed_inc;
    logic        tick_expired;
    logic [31:0] end_word;

    assign need         = kind_reg ? 3'd2 : 3'd4;
    assign hdr          = kind_reg ? HDR_WORD16 : HDR_WORD32;
    assign cnt_inc      = cnt_reg + 3'd1;
    assign elapsed_inc  = {1'b0, elapsed_reg} + 17'd1;
    assign tick_expired = elapsed_inc > {1'b0, timeout_reg};
    assign end_word     = kind_reg ? {16'h0000, acc_reg[15:0]} : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg    <= 1'b0;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_RX_FRAME_KIND: kind_reg    <= cfg_data[0];
                REG_TIMEOUT_TICKS: timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= RX_IDLE;
            cnt_reg     <= '0;
            acc_reg     <= '0;
            elapsed_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            acc_reg     <= acc_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        elapsed_next = elapsed_reg;
        if (accept)
        begin
            case (op_t'(in_item.operation))
                OP_RX_BYTE:
                begin
                    case (phase_reg)
                        RX_GATHER:
                        begin
                            acc_next = acc_reg |
                                ({24'h000000, in_item.rx_data_byte} << {cnt_reg[1:0], 3'b000});
                            cnt_next = cnt_inc;
                            if (cnt_inc >= need)
                                phase_next = RX_END;
                        end
                        RX_END:
                        begin
                            phase_next   = RX_IDLE;
                            cnt_next     = '0;
                            acc_next     = '0;
                            elapsed_next = '0;
                        end
                        default:
                        begin
                            phase_next   = (in_item.rx_data_byte == hdr) ? RX_GATHER : RX_IDLE;
                            cnt_next     = '0;
                            acc_next     = '0;
                            elapsed_next = '0;
                        end
                    endcase
                end
                OP_TICK:
                begin
                    if (phase_reg != RX_IDLE)
                    begin
                        if (tick_expired)
                        begin
                            phase_next   = RX_IDLE;
                            cnt_next     = '0;
                            acc_next     = '0;
                            elapsed_next = '0;
                        end
                        else
                            elapsed_next = elapsed_inc[15:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // command issue
    always_comb
    begin
        cmd_push       = 1'b0;
        cmd.is_send    = 1'b0;
        cmd.word       = '0;
        cmd.send_kind  = in_item.send_kind;
        cmd.rx_done    = 1'b0;
        cmd.rx_fail    = 1'b0;
        cmd.fail_cause = CAUSE_HEADER;
        if (accept)
        begin
            case (op_t'(in_item.operation))
                OP_RX_BYTE:
                begin
                    case (phase_reg)
                        RX_GATHER: ;
                        RX_END:
                        begin
                            cmd_push = 1'b1;
                            if (in_item.rx_data_byte == END_BYTE)
                            begin
                                cmd.rx_done = 1'b1;
                                cmd.word    = end_word;
                            end
                            else
                            begin
                                cmd.rx_fail    = 1'b1;
                                cmd.fail_cause = CAUSE_END;
                            end
                        end
                        default:
                        begin
                            if (in_item.rx_data_byte != hdr)
                            begin
                                cmd_push       = 1'b1;
                                cmd.rx_fail    = 1'b1;
                                cmd.fail_cause = CAUSE_HEADER;
                            end
                        end
                    endcase
                end
                OP_TICK:
                begin
                    if (phase_reg != RX_IDLE && tick_expired)
                    begin
                        cmd_push       = 1'b1;
                        cmd.rx_fail    = 1'b1;
                        cmd.fail_cause = CAUSE_TIMEOUT;
                    end
                end
                OP_SEND:
                begin
                    cmd_push    = 1'b1;
                    cmd.is_send = 1'b1;
                    cmd.word    = in_item.send_word;
                end
                default: ;
            endcase
        end
    end

endmodule

/* hdl/svfc_cmd_fifo.sv */
// Command queue between front and back ends.
// Depends on svfc_pkg.
module svfc_cmd_fifo #(
    parameter int DEPTH = svfc_pkg::CMD_DEPTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr,
    input  svfc_pkg::cmd_t         wr_data,
    input  logic                   rd,
    output svfc_pkg::cmd_t         rd_data,
    output svfc_pkg::fifo_status_t status
);
    import svfc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr, do_rd;

    assign status.full  = count_reg == FULL_CNT;
    assign status.empty = count_reg == '0;
    assign do_wr        = wr && !status.full;
    assign do_rd        = rd && !status.empty;
    assign rd_data      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CW'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

/* hdl/svfc_back.sv */
// Back end: expands send commands into link bytes, holds the output result.
// Depends on svfc_pkg.
module svfc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  svfc_pkg::cmd_t         cmd,
    input  logic                   cmd_valid,
    output logic                   cmd_pop,
    input  logic                   pop,
    output logic                   empty,
    output svfc_pkg::out_item_t    out_item
);
    import svfc_pkg::*;

    logic       out_valid_reg;
    out_item_t  out_reg;
    logic [2:0] step_reg;
    logic [2:0] last_step;
    logic       load;
    logic [7:0] tx_byte;
    out_item_t  res;

    assign last_step = cmd.send_kind ? 3'd3 : 3'd5;
    assign load      = cmd_valid && (!out_valid_reg || pop);
    assign cmd_pop   = load && (!cmd.is_send || step_reg == last_step);
    assign empty     = !out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        case (step_reg)
            3'd0:    tx_byte = cmd.send_kind ? HDR_WORD16 : HDR_WORD32;
            3'd1:    tx_byte = cmd.word[7:0];
            3'd2:    tx_byte = cmd.word[15:8];
            3'd3:    tx_byte = cmd.send_kind ? END_BYTE : cmd.word[23:16];
            3'd4:    tx_byte = cmd.word[31:24];
            default: tx_byte = END_BYTE;
        endcase
    end

    always_comb
    begin
        res = '0;
        if (cmd.is_send)
        begin
            res.tx_valid     = 1'b1;
            res.tx_data_byte = tx_byte;
            res.tx_last      = step_reg == last_step;
        end
        else
        begin
            res.rx_done    = cmd.rx_done;
            res.rx_word    = cmd.word;
            res.rx_fail    = cmd.rx_fail;
            res.fail_cause = cmd.fail_cause;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            if (load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
            if (load && cmd.is_send)
                step_reg <= (step_reg == last_step) ? 3'd0 : step_reg + 3'd1;
        end
    end

endmodule

/* hdl/serial_value_frame_codec_core.sv */
// A result passes through the command queue and the back-end output register to the result ports.
// The front takes one receive byte or tick per cycle while the queue is not full; a send
// yields 4 or 6 bytes, one per cycle from the back-end byte sequencer as results pop.
// The command queue (CMD_DEPTH entries) lets the front keep accepting during a send.
// Reset clears receive state, queue and output; registers return to kind 0, 1000 ticks.
// Top level: front end, command queue, back end. Depends on svfc_pkg.
module serial_value_frame_codec_core #(
    parameter int CMD_DEPTH = svfc_pkg::CMD_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  svfc_pkg::in_item_t   in_item,
    output logic                 empty,
    input  logic                 pop,
    output svfc_pkg::out_item_t  out_item,
    input  logic                 cfg_write,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_data
);
    import svfc_pkg::*;

    logic         accept;
    logic         cmd_push;
    cmd_t         cmd_in, cmd_head;
    logic         cmd_pop;
    fifo_status_t q_status;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    svfc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_item   (in_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    svfc_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (cmd_push),
        .wr_data (cmd_in),
        .rd      (cmd_pop),
        .rd_data (cmd_head),
        .status  (q_status)
    );

    svfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_head),
        .cmd_valid (!q_status.empty),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .out_item  (out_item)
    );

endmodule

/* hdl/svfc_checker.sv */
// Port-level checks for the codec core, attached by bind.
// Depends on svfc_pkg and serial_value_frame_codec_core.
module svfc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input svfc_pkg::out_item_t out_item
);
    import svfc_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_item))
        else $error("waiting result changed before transfer");

    a_tx_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && out_item.tx_valid |->
            !out_item.rx_done && !out_item.rx_fail && out_item.rx_word == '0)
        else $error("transmit result carries receive fields");

    a_rx_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !out_item.tx_valid |->
            (out_item.rx_done ^ out_item.rx_fail) && !out_item.tx_last &&
            out_item.tx_data_byte == 8'h00)
        else $error("receive result malformed");

    a_fail_word: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && out_item.rx_fail |->
            out_item.rx_word == '0 && out_item.fail_cause != 2'd3)
        else $error("failure result malformed");

    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && out_item.tx_last |-> out_item.tx_valid && out_item.tx_data_byte == END_BYTE)
        else $error("last transmit byte is not the end byte");

endmodule

bind serial_value_frame_codec_core svfc_checker u_svfc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);
